[rtl/core/fct_pkg.sv]
// Shared types and constants for the frustum cull test core.
package fct_pkg;

  localparam int COORD_W  = 16;
  localparam int RAD_W    = 15;
  localparam int FRAC_W   = 14;
  localparam int PROD_W   = 32;
  localparam int DIST_W   = 35;
  localparam int REG_W    = 64;
  localparam int REG_COUNT = 6;
  localparam int IDX_W    = 3;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] lz;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hy;
    logic signed [COORD_W-1:0] hz;
    logic [RAD_W-1:0]          radius;
  } item_t;

  // Item travelling down the cell chain with its running verdict.
  typedef struct packed {
    logic  valid;
    item_t item;
    logic  culled;
  } token_t;

endpackage

[rtl/core/fct_cell.sv]
// One plane cell: tests the passing item against its plane over two stages.
module fct_cell
  import fct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             plane_on,
  input  logic [REG_W-1:0] plane,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic signed [COORD_W-1:0] a, b, c, d;
  assign a = plane[15:0];
  assign b = plane[31:16];
  assign c = plane[47:32];
  assign d = plane[63:48];

  // Stage 1: products. Box uses min and max corner terms per axis.
  token_t tok_r;
  logic signed [PROD_W-1:0] ax0_r, ax1_r, by0_r, by1_r, cz0_r, cz1_r;
  logic signed [DIST_W-1:0] dterm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r.valid <= tok_in.valid;
    end
    if (en) begin
      tok_r.item   <= tok_in.item;
      tok_r.culled <= tok_in.culled;
      ax0_r <= a * tok_in.item.lx;
      ax1_r <= a * tok_in.item.hx;
      by0_r <= b * tok_in.item.ly;
      by1_r <= b * tok_in.item.hy;
      cz0_r <= c * tok_in.item.lz;
      cz1_r <= c * tok_in.item.hz;
      dterm_r <= DIST_W'(d) <<< FRAC_W;
    end
  end

  // Stage 2: sums and compare. Box max distance takes the larger term per axis.
  logic signed [PROD_W-1:0] mx, my, mz;
  logic signed [DIST_W-1:0] dist0, distm, thr;
  logic cull;
  assign mx = (ax1_r > ax0_r) ? ax1_r : ax0_r;
  assign my = (by1_r > by0_r) ? by1_r : by0_r;
  assign mz = (cz1_r > cz0_r) ? cz1_r : cz0_r;
  assign dist0 = DIST_W'(ax0_r) + DIST_W'(by0_r) + DIST_W'(cz0_r) + dterm_r;
  assign distm = DIST_W'(mx) + DIST_W'(my) + DIST_W'(mz) + dterm_r;
  assign thr = -(DIST_W'($signed({1'b0, tok_r.item.radius})) <<< FRAC_W);

  always_comb begin
    case (kind_t'(tok_r.item.kind))
      KIND_POINT:  cull = (dist0 <= 0);
      KIND_SPHERE: cull = (dist0 <= thr);
      KIND_BOX:    cull = (distm <= 0);
      default:     cull = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_r.valid;
    end
    if (en) begin
      tok_out.item   <= tok_r.item;
      tok_out.culled <= tok_r.culled | (plane_on & cull);
    end
  end

endmodule

[rtl/core/frustum_cull_test_core.sv]
// Top level: frustum cull test as a chain of plane cells.
//
// channel | dir | request contents
// in_     | in  | tdata: low_x, low_y, low_z, high_x, high_y, high_z, radius; tuser: kind
// out_    | out | tdata: visible
// cfg_    | in  | plane register write, index 0..5
//
// One item per cycle while the chain is not stalled by the output; each cell in the chain is
// a multiply stage and a sum/compare stage.
// Reset (synchronous, rst_n low) clears planes and valid flags.
// The whole chain advances only while the last stage is empty or taken.
module frustum_cull_test_core
  import fct_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [15:0] low_x, [31:16] low_y, [47:32] low_z, [63:48] high_x,
  // [79:64] high_y, [95:80] high_z, [110:96] sphere_radius, [111] zero
  input  logic [111:0]     in_tdata,
  // [1:0] kind
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] visible, [7:1] zero
  output logic [7:0]       out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  logic [REG_W-1:0] planes_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) planes_r[i] <= '0;
    end else if (cfg_we && (cfg_index < IDX_W'(REG_COUNT))) begin
      planes_r[cfg_index] <= cfg_wdata;
    end
  end

  token_t chain [PLANE_COUNT+1];
  logic en;
  assign en = !chain[PLANE_COUNT].valid || out_tready;
  assign in_tready = en;

  always_comb begin
    chain[0].valid       = in_tvalid;
    chain[0].item.kind   = in_tuser;
    chain[0].item.lx     = in_tdata[15:0];
    chain[0].item.ly     = in_tdata[31:16];
    chain[0].item.lz     = in_tdata[47:32];
    chain[0].item.hx     = in_tdata[63:48];
    chain[0].item.hy     = in_tdata[79:64];
    chain[0].item.hz     = in_tdata[95:80];
    chain[0].item.radius = in_tdata[110:96];
    chain[0].culled      = 1'b0;
  end

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    // planes past the sixth do not exist and never cull
    localparam int PI = (g < REG_COUNT) ? g : 0;
    fct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .plane_on (g < REG_COUNT),
      .plane    (planes_r[PI]),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  assign out_tvalid = chain[PLANE_COUNT].valid;
  assign out_tdata  = {7'd0, ~chain[PLANE_COUNT].culled};

  property p_hold_valid;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid;
  endproperty
  a_hold_valid: assert property (p_hold_valid) else $error("result dropped while stalled");

  property p_stall_hold;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> $stable(out_tdata);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");

  property p_ready;
    @(posedge clk) disable iff (!rst_n)
      !out_tvalid |-> in_tready;
  endproperty
  a_ready: assert property (p_ready) else $error("input blocked with empty output");

endmodule

[tb/sv/frustum_cull_test_core_tb.sv]
// Testbench for the frustum cull core: random plane sets, objects and handshake gaps.
`timescale 1ns / 100ps

module frustum_cull_test_core_tb;
  import fct_pkg::*;

  localparam int N_PLANES = 6;
  localparam int LATENCY = 2 * N_PLANES + 4;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  frustum_cull_test_core #(.PLANE_COUNT(N_PLANES)) DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  logic [REG_W-1:0] planes [REG_COUNT];
  item_t pending_reqs [$];
  logic visible_q [$];
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0, gap_left = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;

  function automatic longint signed dist_of(input logic [REG_W-1:0] p,
      input longint signed x, input longint signed y, input longint signed z);
    longint signed a, b, c, d;
    a = $signed(p[15:0]);
    b = $signed(p[31:16]);
    c = $signed(p[47:32]);
    d = $signed(p[63:48]);
    return a * x + b * y + c * z + d * 16384;
  endfunction

  function automatic logic predict_visible(input item_t it);
    longint signed r;
    logic culled;
    r = it.radius;
    if (it.kind == KIND_NONE) return 1'b1;
    for (int i = 0; i < N_PLANES && i < REG_COUNT; i++) begin
      case (kind_t'(it.kind))
        KIND_POINT: culled = dist_of(planes[i], it.lx, it.ly, it.lz) <= 0;
        KIND_SPHERE: culled = dist_of(planes[i], it.lx, it.ly, it.lz) <= -(r * 16384);
        default: begin
          culled = 1'b1;
          for (int c = 0; c < 8; c++)
            if (dist_of(planes[i], c[0] ? it.hx : it.lx, c[1] ? it.hy : it.ly,
                        c[2] ? it.hz : it.lz) > 0) culled = 1'b0;
        end
      endcase
      if (culled) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: bursts and gaps; the prediction is made at acceptance.
  always @(posedge clk) begin
    item_t it;
    cycles <= cycles + 1;
    if (in_tvalid && in_tready) begin
      it = {in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32],
            in_tdata[63:48], in_tdata[79:64], in_tdata[95:80], in_tdata[110:96]};
      visible_q.push_back(predict_visible(it));
    end
    if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && rst_n) begin
        it = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.kind;
        in_tdata <= {1'b0, it.radius, it.hz, it.hy, it.hx, it.lz, it.ly, it.lx};
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(30);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else in_tvalid <= 1'b0;
    end
  end

  // Monitor with its own stall pattern and one long hold-off.
  always @(posedge clk) begin
    logic expd;
    if (out_tvalid && out_tready) begin
      if (visible_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible=%0b",
                 $time, out_tdata[0]);
        errors++;
      end else begin
        expd = visible_q.pop_front();
        if (out_tdata[0] !== expd || out_tdata[7:1] !== 7'd0) begin
          $display("%0t: visible mismatch, expected %0b, actual %0b (tdata %h)",
                   $time, expd, out_tdata[0], out_tdata);
          errors++;
        end
      end
    end
    if (hold_armed) begin
      hold_armed <= 1'b0;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if ((cycles / 200) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(3) != 0);
  end

  task automatic write_plane(input int idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_wdata <= val;
    planes[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_tvalid || visible_q.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(4000))) - 16'sd2000;
      default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int m;
    m = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
    it.kind = ($urandom_range(15) == 0) ? KIND_NONE : 2'($urandom_range(2));
    it.lx = rand_coord(m); it.ly = rand_coord(m); it.lz = rand_coord(m);
    it.hx = rand_coord(m); it.hy = rand_coord(m); it.hz = rand_coord(m);
    if (it.kind == KIND_BOX && $urandom_range(3) != 0) begin
      if (it.hx < it.lx) it.hx = it.lx + 16'sd300;
      if (it.hy < it.ly) it.hy = it.ly + 16'sd300;
      if (it.hz < it.lz) it.hz = it.lz + 16'sd300;
    end
    it.radius = (m == 2) ? 15'h7fff
              : ($urandom_range(1) ? 15'($urandom) : 15'($urandom_range(1500)));
    return it;
  endfunction

  // A plane: fully random bits in mode 0, else a unit-ish normal and an offset near the cube of interest.
  function automatic logic [REG_W-1:0] rand_plane(input int mode);
    logic [15:0] a, b, c, d;
    if (mode == 0) return {$urandom, $urandom};
    a = 16'($urandom_range(16384 * 2) - 16384);
    b = 16'($urandom_range(16384 * 2) - 16384);
    c = 16'($urandom_range(16384 * 2) - 16384);
    d = 16'($urandom_range(3000));
    return {d, c, b, a};
  endfunction

  function automatic item_t mk(input kind_t k, input logic signed [15:0] v,
                               input logic signed [15:0] w, input logic [14:0] r);
    item_t it;
    it.kind = k; it.lx = v; it.ly = v; it.lz = v;
    it.hx = w; it.hy = w; it.hz = w; it.radius = r;
    return it;
  endfunction

  initial begin
    for (int i = 0; i < REG_COUNT; i++) planes[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Reset planes: points and boxes culled, spheres visible unless radius is zero.
    pending_reqs.push_back(mk(KIND_POINT, 16'sd0, 16'sd0, 15'd0));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sd5, 16'sd0, 15'd0));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sd5, 16'sd0, 15'h7fff));
    pending_reqs.push_back(mk(KIND_BOX, -16'sd5, 16'sd5, 15'd0));
    pending_reqs.push_back(mk(KIND_NONE, 16'sd0, 16'sd0, 15'd0));
    drain();
    // Extreme plane coefficients.
    write_plane(0, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    write_plane(1, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    write_plane(2, {16'h7fff, 16'h8000, 16'h0000, 16'h4000});
    write_plane(3, {16'h0001, 16'h0000, 16'h0000, 16'h0000});
    write_plane(4, 64'hffff_ffff_ffff_ffff);
    write_plane(5, {16'd100, 16'h0000, 16'h4000, 16'h0000});
    pending_reqs.push_back(mk(KIND_POINT, 16'sh7fff, 16'sh8000, 15'h7fff));
    pending_reqs.push_back(mk(KIND_POINT, 16'sh8000, 16'sh7fff, 15'd0));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sh7fff, 16'sd0, 15'h7fff));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sh8000, 16'sd0, 15'h7fff));
    pending_reqs.push_back(mk(KIND_BOX, 16'sh8000, 16'sh7fff, 15'h7fff));
    pending_reqs.push_back(mk(KIND_BOX, 16'sh7fff, 16'sh8000, 15'd0)); // inverted box
    pending_reqs.push_back(mk(KIND_NONE, 16'sh8000, 16'sh7fff, 15'h7fff));
    drain();
    // A plane set that gives a box-shaped volume, x,y,z in -999..999 (open range -1000 to 1000).
    write_plane(0, {16'd1000, 16'h0000, 16'h0000, 16'h4000});
    write_plane(1, {16'd1000, 16'h0000, 16'h0000, 16'hc000});
    write_plane(2, {16'd1000, 16'h0000, 16'h4000, 16'h0000});
    write_plane(3, {16'd1000, 16'h0000, 16'hc000, 16'h0000});
    write_plane(4, {16'd1000, 16'h4000, 16'h0000, 16'h0000});
    write_plane(5, {16'd1000, 16'hc000, 16'h0000, 16'h0000});
    pending_reqs.push_back(mk(KIND_POINT, 16'sd1000, 16'sd0, 15'd0));
    pending_reqs.push_back(mk(KIND_POINT, 16'sd999, 16'sd0, 15'd0));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sd1100, 16'sd0, 15'd100));
    pending_reqs.push_back(mk(KIND_SPHERE, 16'sd1100, 16'sd0, 15'd101));
    pending_reqs.push_back(mk(KIND_BOX, 16'sd1000, 16'sd2000, 15'd0));
    pending_reqs.push_back(mk(KIND_BOX, 16'sd999, 16'sd2000, 15'd0));
    hold_armed <= 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 190; k++) pending_reqs.push_back(rand_item());
      drain();
      for (int i = 0; i < REG_COUNT; i++) write_plane(i, rand_plane(phase % 3));
    end
    drain();
    if (errors == 0) $display("frustum_cull_test_core: match");
    else $display("frustum_cull_test_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("frustum_cull_test_core: mismatch");
      $finish;
    end
  end

endmodule

[frustum_cull_test_core.f]
rtl/core/fct_pkg.sv
rtl/core/fct_cell.sv
rtl/core/frustum_cull_test_core.sv
tb/sv/frustum_cull_test_core_tb.sv
